// ----- rtl/pcxrle_pkg.sv -----
// Package: shared types and constants of the PCX run-length palette decoder.
`timescale 1ns / 1ps
package pcxrle_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned DIM_W      = 17;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned RGB_W      = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_STRIDE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  localparam logic [7:0]       RUN_MARK = 8'hC0;
  localparam logic [RUN_W-1:0] RUN_MASK = 6'h3F;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dec_state_t;

endpackage

// ----- rtl/pcxrle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcxrle_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pcx_rle_palette_decoder.sv -----
// On acceptance the palette read and the run state are registered; each run step then
// registers its pixel. Throughput: one run pixel per cycle out of the palette RAM's
// registered read port while the output is not stalled; input waits until a run ends.
// Run headers and palette writes give no result.
// Reset (synchronous, rst_n low): registers to 1, decoder position and run state to zero;
// palette contents are undefined until written.
`timescale 1ns / 1ps
module pcx_rle_palette_decoder #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,  // data_byte, palette_index, palette_rgb
  input  logic                                in_tuser,  // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata, // red, green, blue
  output logic [1:0]                          out_tuser, // row_end, image_end
  output logic                                out_tlast, // last_of_run
  input  logic                                cfg_wr_en,
  input  logic [pcxrle_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [pcxrle_pkg::STRIDE_W-1:0] stride_r;
  logic [pcxrle_pkg::DIM_W-1:0]    width_r;
  logic [pcxrle_pkg::DIM_W-1:0]    height_r;

  pcxrle_pkg::dec_state_t state_r, state_nxt;
  logic                         awaiting_r, awaiting_nxt;
  logic [pcxrle_pkg::RUN_W-1:0] pend_r, pend_nxt;
  logic [pcxrle_pkg::RUN_W-1:0] cnt_r, cnt_nxt;
  logic [pcxrle_pkg::POS_W-1:0] col_r, col_nxt;
  logic [pcxrle_pkg::POS_W-1:0] row_r, row_nxt;
  logic                         oor_r, oor_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [pcxrle_pkg::RGB_W-1:0] out_rgb_r;
  logic                         out_row_end_r, out_image_end_r, out_last_r;

  logic                         in_acc;
  logic                         in_op;
  logic [7:0]                   in_byte;
  logic [7:0]                   in_pidx;
  logic [pcxrle_pkg::RGB_W-1:0] in_prgb;
  logic                         pal_wr;
  logic [pcxrle_pkg::RGB_W-1:0] pal_rdata;
  logic [pcxrle_pkg::RGB_W-1:0] pix_rgb;

  logic [pcxrle_pkg::DIM_W-1:0] col17, colp1, stride_eff, height_eff, rowp1, visible;
  logic                         line_done, last_row, emit, last_pix, row_end, stall, step;

  assign in_op   = in_tuser;
  assign in_byte = in_tdata[7:0];
  assign in_pidx = in_tdata[15:8];
  assign in_prgb = in_tdata[39:16];

  assign in_tready = (state_r == pcxrle_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign pal_wr    = in_acc && (in_op == pcxrle_pkg::OP_PALETTE)
                     && ({1'b0, in_pidx} < 9'(PALETTE_ENTRIES));

  pcxrle_ram #(
    .WIDTH (pcxrle_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (in_pidx[AW-1:0]),
    .wr_data (in_prgb),
    .rd_en   (in_acc && (in_op == pcxrle_pkg::OP_DATA)),
    .rd_addr (in_byte[AW-1:0]),
    .rd_data (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= pcxrle_pkg::STRIDE_W'(1);
      width_r  <= pcxrle_pkg::DIM_W'(1);
      height_r <= pcxrle_pkg::DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pcxrle_pkg::CFG_LINE_STRIDE:  stride_r <= cfg_wdata[pcxrle_pkg::STRIDE_W-1:0];
        pcxrle_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        pcxrle_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign stride_eff = (stride_r == '0) ? pcxrle_pkg::DIM_W'(1) : {1'b0, stride_r};
  assign height_eff = (height_r == '0) ? pcxrle_pkg::DIM_W'(1) : height_r;
  assign visible    = (width_r < stride_eff) ? width_r : stride_eff;
  assign col17      = {1'b0, col_r};
  assign colp1      = col17 + pcxrle_pkg::DIM_W'(1);
  assign rowp1      = {1'b0, row_r} + pcxrle_pkg::DIM_W'(1);
  assign line_done  = colp1 >= stride_eff;
  assign last_row   = rowp1 >= height_eff;
  assign emit       = col17 < width_r;
  assign last_pix   = (cnt_r == pcxrle_pkg::RUN_W'(1)) || line_done || (colp1 >= width_r);
  assign row_end    = (visible != '0) && (col17 == visible - pcxrle_pkg::DIM_W'(1));
  assign stall      = emit && out_valid_r && !out_tready;
  assign step       = (state_r == pcxrle_pkg::ST_RUN) && !stall;
  assign pix_rgb    = oor_r ? '0 : pal_rdata;

  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      pcxrle_pkg::ST_IDLE: begin
        if (in_acc && (in_op == pcxrle_pkg::OP_DATA)) begin
          oor_nxt = {1'b0, in_byte} >= 9'(PALETTE_ENTRIES);
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            cnt_nxt      = pend_r;
            if (pend_r != '0) begin
              state_nxt = pcxrle_pkg::ST_RUN;
            end
          end else if (in_byte >= pcxrle_pkg::RUN_MARK) begin
            awaiting_nxt = 1'b1;
            pend_nxt     = in_byte[pcxrle_pkg::RUN_W-1:0] & pcxrle_pkg::RUN_MASK;
          end else begin
            cnt_nxt   = pcxrle_pkg::RUN_W'(1);
            state_nxt = pcxrle_pkg::ST_RUN;
          end
        end
      end
      pcxrle_pkg::ST_RUN: begin
        if (step) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
          end
          cnt_nxt = cnt_r - pcxrle_pkg::RUN_W'(1);
          if (line_done) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : rowp1[pcxrle_pkg::POS_W-1:0];
          end else begin
            col_nxt = colp1[pcxrle_pkg::POS_W-1:0];
          end
          if (line_done || (cnt_r == pcxrle_pkg::RUN_W'(1))) begin
            state_nxt = pcxrle_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = pcxrle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcxrle_pkg::ST_IDLE;
      awaiting_r  <= 1'b0;
      pend_r      <= '0;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      oor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      oor_r       <= oor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_rgb_r       <= pix_rgb;
      out_row_end_r   <= row_end;
      out_image_end_r <= row_end && last_row;
      out_last_r      <= last_pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rgb_r[7:0], out_rgb_r[15:8], out_rgb_r[23:16]};
  assign out_tuser  = {out_image_end_r, out_row_end_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_run_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcxrle_pkg::ST_RUN) |-> (cnt_r != '0))
    else $error("run state entered with zero count");

  a_palette_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == pcxrle_pkg::OP_PALETTE)) |=>
      ($stable(col_r) && $stable(row_r) && $stable(awaiting_r)))
    else $error("palette write disturbed decoder state");

  a_literal_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == pcxrle_pkg::OP_DATA) && !awaiting_r
      && (in_byte < pcxrle_pkg::RUN_MARK)) |=> (state_r == pcxrle_pkg::ST_RUN))
    else $error("literal byte did not start a run");

  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_image_end_r) |-> out_row_end_r)
    else $error("image end without row end");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the PCX run-length palette decoder: directed script, then random traffic.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
    logic       run_last;
  } pixel_t;

  typedef enum logic {
    ROW_REG,
    ROW_REQ
  } row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [pcxrle_pkg::CFG_ADDR_W-1:0] addr;
    logic                              op;
    logic [pcxrle_pkg::CFG_DATA_W-1:0] val;
    logic [7:0]                        pidx;
    logic [pcxrle_pkg::RGB_W-1:0]      prgb;
    logic                              typed;
    logic [pcxrle_pkg::RGB_W-1:0]      exp_rgb;
    logic                              exp_re;
    logic                              exp_ie;
  } script_row_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic [39:0]                       in_tdata   = '0;  // data_byte, palette_index, palette_rgb
  logic                              in_tuser   = 1'b0; // operation
  logic                              out_tready = 1'b0;
  logic                              cfg_wr_en  = 1'b0;
  logic [pcxrle_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [pcxrle_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                              in_tready;
  logic                              out_tvalid;
  logic [23:0]                       out_tdata;  // red, green, blue
  logic [1:0]                        out_tuser;  // row_end, image_end
  logic                              out_tlast;  // last_of_run

  // decoder mirror
  int unsigned                  geo_stride = 1;
  int unsigned                  geo_width  = 1;
  int unsigned                  geo_height = 1;
  bit                           run_armed  = 1'b0;
  logic [pcxrle_pkg::RUN_W-1:0] run_len    = '0;
  logic [pcxrle_pkg::POS_W-1:0] col_pos    = '0;
  logic [pcxrle_pkg::POS_W-1:0] row_pos    = '0;
  logic [pcxrle_pkg::RGB_W-1:0] palette     [256];
  bit                           pal_written [256];

  pixel_t      pixels_due[$];
  script_row_t script[$];
  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  pcx_rle_palette_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void add_reg(logic [pcxrle_pkg::CFG_ADDR_W-1:0] a,
                                  logic [pcxrle_pkg::CFG_DATA_W-1:0] v);
    script_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.addr = a;
    r.val  = v;
    script.insert(script.size(), r);
  endfunction

  function automatic void add_req(logic op, logic [7:0] b, logic [7:0] pidx,
                                  logic [pcxrle_pkg::RGB_W-1:0] prgb);
    script_row_t r;
    r      = '0;
    r.kind = ROW_REQ;
    r.op   = op;
    r.val  = pcxrle_pkg::CFG_DATA_W'(b);
    r.pidx = pidx;
    r.prgb = prgb;
    script.insert(script.size(), r);
  endfunction

  function automatic void add_pixel(logic [7:0] b, logic [pcxrle_pkg::RGB_W-1:0] rgb, logic re,
                                    logic ie);
    script_row_t r;
    r         = '0;
    r.kind    = ROW_REQ;
    r.op      = pcxrle_pkg::OP_DATA;
    r.val     = pcxrle_pkg::CFG_DATA_W'(b);
    r.typed   = 1'b1;
    r.exp_rgb = rgb;
    r.exp_re  = re;
    r.exp_ie  = ie;
    script.insert(script.size(), r);
  endfunction

  function automatic logic [7:0] pick_entry(int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi);
    while (!pal_written[v]) v = $urandom_range(hi);
    return v[7:0];
  endfunction

  task automatic decode_request(input logic op, input logic [7:0] b, input logic [7:0] pidx,
                                input logic [pcxrle_pkg::RGB_W-1:0] prgb);
    int unsigned                  count;
    int unsigned                  stride;
    int unsigned                  height;
    int unsigned                  visible;
    int unsigned                  colv;
    int                           n;
    bit                           line_done;
    bit                           last_row;
    logic [pcxrle_pkg::RGB_W-1:0] rgb;
    pixel_t                       px;
    if (op == pcxrle_pkg::OP_PALETTE) begin
      palette[pidx]     = prgb;
      pal_written[pidx] = 1'b1;
      return;
    end
    if (run_armed) begin
      run_armed = 1'b0;
      count     = 32'(run_len);
    end else if (b >= pcxrle_pkg::RUN_MARK) begin
      run_armed = 1'b1;
      run_len   = b[pcxrle_pkg::RUN_W-1:0] & pcxrle_pkg::RUN_MASK;
      return;
    end else begin
      count = 1;
    end
    stride  = (geo_stride == 0) ? 1 : geo_stride;
    height  = (geo_height == 0) ? 1 : geo_height;
    visible = (geo_width < stride) ? geo_width : stride;
    n       = 0;
    for (int unsigned k = 0; k < count; k++) begin
      colv      = 32'(col_pos);
      line_done = (colv + 1) >= stride;
      last_row  = (int'(row_pos) + 1) >= height;
      if (colv < geo_width && n < 63) begin
        rgb          = palette[b];
        px.red       = rgb[23:16];
        px.green     = rgb[15:8];
        px.blue      = rgb[7:0];
        px.row_end   = (visible != 0) && (colv == visible - 1);
        px.image_end = px.row_end && last_row;
        px.run_last  = 1'b0;
        pixels_due.insert(pixels_due.size(), px);
        n++;
      end
      if (line_done) begin
        col_pos = '0;
        row_pos = last_row ? '0 : row_pos + 1'b1;
        break;
      end
      col_pos = pcxrle_pkg::POS_W'(colv + 1);
    end
    if (n > 0) begin
      px          = pixels_due.pop_back();
      px.run_last = 1'b1;
      pixels_due.insert(pixels_due.size(), px);
    end
  endtask

  task automatic send_request(input logic op, input logic [7:0] b, input logic [7:0] pidx,
                              input logic [pcxrle_pkg::RGB_W-1:0] prgb);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {prgb, pidx, b};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    logic [7:0]                   b;
    logic [7:0]                   pidx;
    logic [pcxrle_pkg::RGB_W-1:0] prgb;
    logic [pcxrle_pkg::RUN_W-1:0] len;
    logic                         op;
    int unsigned                  sel;
    b    = 8'($urandom);
    pidx = 8'($urandom);
    prgb = pcxrle_pkg::RGB_W'($urandom);
    sel  = $urandom_range(99);
    op   = pcxrle_pkg::OP_DATA;
    if (sel < 8) begin
      op = pcxrle_pkg::OP_PALETTE;
    end else if (run_armed) begin
      b = pick_entry(255);
    end else if (sel < 16) begin
      len = $urandom_range(1) ? pcxrle_pkg::RUN_MASK : '0;
      b   = pcxrle_pkg::RUN_MARK | {2'b00, len};
    end else if (sel < 58) begin
      b = pick_entry(32'(pcxrle_pkg::RUN_MARK) - 1);
    end else begin
      len = ($urandom_range(9) < 7) ? pcxrle_pkg::RUN_W'($urandom_range(1, 8))
                                    : pcxrle_pkg::RUN_W'($urandom_range(0, 63));
      b   = pcxrle_pkg::RUN_MARK | {2'b00, len};
    end
    send_request(op, b, pidx, prgb);
    decode_request(op, b, pidx, prgb);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0 || !in_tready) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcxrle_pkg::CFG_ADDR_W-1:0] a,
                           input logic [pcxrle_pkg::CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (a)
      pcxrle_pkg::CFG_LINE_STRIDE:  geo_stride = 32'(v[pcxrle_pkg::STRIDE_W-1:0]);
      pcxrle_pkg::CFG_IMAGE_WIDTH:  geo_width  = 32'(v);
      pcxrle_pkg::CFG_IMAGE_HEIGHT: geo_height = 32'(v);
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser[0], out_tuser[1],
             out_tlast};
      if (pixels_due.size() == 0) begin
        report_mismatch("unrequested pixel", 32'(got), 32'd0);
      end else begin
        want = pixels_due.pop_front();
        check_field("red", 32'(got.red), 32'(want.red));
        check_field("green", 32'(got.green), 32'(want.green));
        check_field("blue", 32'(got.blue), 32'(want.blue));
        check_field("row_end", 32'(got.row_end), 32'(want.row_end));
        check_field("image_end", 32'(got.image_end), 32'(want.image_end));
        check_field("last_of_run", 32'(got.run_last), 32'(want.run_last));
      end
    end
  end

  initial begin
    int unsigned s;
    int unsigned w;
    int unsigned h;
    int          n0;
    script_row_t r;

    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'h00, 24'h000000);
    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'hFF, 24'hFFFFFF);
    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'hBF, 24'hA5C3E1);
    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'h3F, 24'h123456);
    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'hC0, 24'h5A0F96);
    add_pixel(8'h00, 24'h000000, 1'b1, 1'b1);
    add_pixel(8'hBF, 24'hA5C3E1, 1'b1, 1'b1);
    add_req(pcxrle_pkg::OP_DATA, 8'hFF, 8'h00, 24'h0);
    add_pixel(8'hFF, 24'hFFFFFF, 1'b1, 1'b1);
    add_req(pcxrle_pkg::OP_DATA, 8'hC0, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'h3F, 8'h00, 24'h0);
    add_reg(pcxrle_pkg::CFG_LINE_STRIDE, 17'd65535);
    add_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, 17'd65536);
    add_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, 17'd65536);
    add_req(pcxrle_pkg::OP_DATA, 8'hFE, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_PALETTE, 8'h00, 8'h80, 24'h00FF00);
    add_req(pcxrle_pkg::OP_DATA, 8'h80, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'h3F, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'hFF, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'hC0, 8'h00, 24'h0);
    add_reg(pcxrle_pkg::CFG_LINE_STRIDE, 17'd8);
    add_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, 17'd5);
    add_req(pcxrle_pkg::OP_DATA, 8'h3F, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'hC9, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'hFF, 8'h00, 24'h0);
    add_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, 17'd1);
    add_req(pcxrle_pkg::OP_DATA, 8'h00, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'hC7, 8'h00, 24'h0);
    add_req(pcxrle_pkg::OP_DATA, 8'h00, 8'h00, 24'h0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      r = script[i];
      if (r.kind == ROW_REG) begin
        drain();
        write_reg(r.addr, r.val);
      end else begin
        send_request(r.op, r.val[7:0], r.pidx, r.prgb);
        n0 = pixels_due.size();
        decode_request(r.op, r.val[7:0], r.pidx, r.prgb);
        if (r.typed) begin
          while (pixels_due.size() > n0) void'(pixels_due.pop_back());
          pixels_due.insert(pixels_due.size(),
                            pixel_t'({r.exp_rgb, r.exp_re, r.exp_ie, 1'b1}));
        end
      end
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin s = 1;     w = 1;     h = 1;     end
        1: begin s = 65535; w = 65536; h = 65536; end
        2: begin s = 8;     w = 5;     h = 3;     end
        3: begin s = 4;     w = 4;     h = 2;     end
        4: begin s = 3;     w = 7;     h = 2;     end
        5: begin s = 16;    w = 1;     h = 4;     end
        6: begin
          s = $urandom_range(1, 40);
          w = $urandom_range(1, 48);
          h = $urandom_range(1, 6);
        end
        default: begin s = 20; w = 65536; h = 1; end
      endcase
      write_reg(pcxrle_pkg::CFG_LINE_STRIDE, pcxrle_pkg::CFG_DATA_W'(s));
      write_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, pcxrle_pkg::CFG_DATA_W'(w));
      write_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, pcxrle_pkg::CFG_DATA_W'(h));
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pcxrle_pkg.sv
rtl/pcxrle_ram.sv
rtl/pcx_rle_palette_decoder.sv
dv/tb_top.sv
